>>> design/cags_pkg.sv
// Shared types and constants for the cellular automaton generation step.
// No dependencies; used by cags_window, the top module and the bench.
`default_nettype none

package cags_pkg;

	localparam int DEFAULT_MAX_WIDTH = 1024;

	localparam int GRID_WIDTH_BITS  = 11;
	localparam int GRID_HEIGHT_BITS = 16;
	// one more than the height: flushing runs one row past the grid
	localparam int ROW_BITS         = GRID_HEIGHT_BITS + 1;

	localparam int RESET_GRID_WIDTH  = 1024;
	localparam int RESET_GRID_HEIGHT = 1024;

	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	// register index, taken from paddr[2]
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	localparam logic CMD_CELL = 1'b0;

	// grid edge handling for the cell leaving the window
	typedef struct packed {
		logic wrap;       // input at column 0: result uses the unshifted window
		logic no_left;
		logic no_right;
		logic no_top;
		logic no_bottom;
	} edge_ctl_t;

endpackage

`default_nettype wire

>>> design/cags_cell.sv
// One cell of the line chain: two bits of row history for one column.
// Depends on nothing.
`default_nettype none

module cags_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire logic       load,
	input  wire logic [1:0] din_new,
	input  wire logic [1:0] din_prev,
	output logic      [1:0] q
);

	logic [1:0] hist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= 2'b00;
		end else if (adv) begin
			hist_q <= load ? din_new : din_prev;
		end
	end

	assign q = hist_q;

endmodule

`default_nettype wire

>>> design/cags_line_chain.sv
// Line store built as a chain of cags_cell; new data enters at a cell chosen by
// the row width and leaves from the last cell exactly one row later.
// Depends on cags_cell.
`default_nettype none

module cags_line_chain #(
	parameter int DEPTH    = 1024,
	parameter int IDX_BITS = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic [IDX_BITS-1:0] entry,
	input  wire logic [1:0]          din,
	output logic      [1:0]          dout
);

	logic [1:0] tap [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [1:0] prev;
		if (k == 0) begin : g_head
			assign prev = din;
		end else begin : g_body
			assign prev = tap[k-1];
		end

		cags_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.load     (entry == IDX_BITS'(k)),
			.din_new  (din),
			.din_prev (prev),
			.q        (tap[k])
		);
	end

	assign dout = tap[DEPTH-1];

endmodule

`default_nettype wire

>>> design/cags_window.sv
// 3x3 window register and the B1/S012345678 rule with edge masking.
// Depends on cags_pkg.
`default_nettype none

module cags_window (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic [1:0]          hist,
	input  wire logic                cell_in,
	input  wire cags_pkg::edge_ctl_t ctl,
	output logic                     next_value
);

	logic [8:0] win_q;
	logic [8:0] shifted;
	logic [2:0] left_c, centre_c, right_c;
	logic [2:0] row_mask;

	// column bits: [2] top, [1] middle, [0] bottom
	assign shifted  = {win_q[5:0], hist[1], hist[0], cell_in};
	assign row_mask = {~ctl.no_top, 1'b1, ~ctl.no_bottom};

	always_comb begin
		if (ctl.wrap) begin
			left_c   = win_q[5:3];
			centre_c = win_q[2:0];
			right_c  = 3'b000;
		end else begin
			left_c   = shifted[8:6];
			centre_c = shifted[5:3];
			right_c  = shifted[2:0];
		end
		if (ctl.no_left)  left_c  = 3'b000;
		if (ctl.no_right) right_c = 3'b000;
		left_c   = left_c & row_mask;
		centre_c = centre_c & row_mask;
		right_c  = right_c & row_mask;
	end

	// born on exactly one live neighbour, never dies
	assign next_value = centre_c[1] | $onehot({left_c, right_c, centre_c[2], centre_c[0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (adv) begin
			win_q <= shifted;
		end
	end

endmodule

`default_nettype wire

>>> design/cellular_automaton_generation_step_top.sv
// Output: a cell's result is produced by the item grid_width + 1 items later and is
// registered in the output register, or in the skid stage while that register is stalled.
// Throughput: one item per cycle unless stalled; chain, window and counters advance per item.
// Reset: grid 1024 x 1024, line chain and window cleared, positions at zero; no clearing pass.
// Depends on cags_pkg, cags_line_chain, cags_window.
`default_nettype none

module cellular_automaton_generation_step_top #(
	parameter int MAX_WIDTH = cags_pkg::DEFAULT_MAX_WIDTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [cags_pkg::APB_ADDR_BITS-1:0] paddr,
	input  wire logic [cags_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic      [cags_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                                    pready,
	input  wire logic                               item_valid,
	output logic                                    item_stall,
	input  wire logic                               cmd,
	input  wire logic                               cell_value,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output logic                                    next_value,
	output logic                                    generation_end
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int GWB = cags_pkg::GRID_WIDTH_BITS;
	localparam int GHB = cags_pkg::GRID_HEIGHT_BITS;
	localparam int RB  = cags_pkg::ROW_BITS;
	localparam int RST_W = (cags_pkg::RESET_GRID_WIDTH > MAX_WIDTH) ?
		MAX_WIDTH : cags_pkg::RESET_GRID_WIDTH;
	localparam logic [CW-1:0]  RST_WLAST = CW'(RST_W - 1);
	localparam logic [GHB-1:0] RST_HLAST = GHB'(cags_pkg::RESET_GRID_HEIGHT - 1);

	// configuration
	logic [GWB-1:0] grid_width_q;
	logic [GHB-1:0] grid_height_q;
	logic [CW-1:0]  wlast_q;
	logic [GHB-1:0] hlast_q;
	logic           cfg_wr;
	logic [GWB-1:0] wsrc;
	logic [GHB-1:0] hsrc;
	logic [CW-1:0]  wlast_d;
	logic [GHB-1:0] hlast_d;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign wsrc   = pwdata[GWB-1:0];
	assign hsrc   = pwdata[GHB-1:0];

	always_comb begin
		if (wsrc == '0) begin
			wlast_d = '0;
		end else if (32'(wsrc) > 32'(MAX_WIDTH)) begin
			wlast_d = CW'(MAX_WIDTH - 1);
		end else begin
			wlast_d = CW'(wsrc - GWB'(1));
		end
		hlast_d = (hsrc == '0) ? '0 : hsrc - GHB'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GWB'(cags_pkg::RESET_GRID_WIDTH);
			grid_height_q <= GHB'(cags_pkg::RESET_GRID_HEIGHT);
			wlast_q       <= RST_WLAST;
			hlast_q       <= RST_HLAST;
		end else if (cfg_wr) begin
			case (paddr[2])
				cags_pkg::REG_GRID_WIDTH: begin
					grid_width_q <= wsrc;
					wlast_q      <= wlast_d;
				end
				cags_pkg::REG_GRID_HEIGHT: begin
					grid_height_q <= hsrc;
					hlast_q       <= hlast_d;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			cags_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width_q);
			cags_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height_q);
			default:                   prdata = '0;
		endcase
	end

	// raster positions
	logic [CW-1:0]  ic_q, oc_q;
	logic [RB-1:0]  ir_q;
	logic [GHB-1:0] or_q;
	logic           item_acc;
	logic           emit;
	logic           gen_end_c;
	logic           cell_c;
	logic [1:0]     hist;
	logic           next_value_c;
	cags_pkg::edge_ctl_t ctl;

	assign item_acc = item_valid & ~item_stall;
	assign emit     = (ir_q > RB'(1)) || (ir_q == RB'(1) && ic_q != '0);
	// cells past the last row count as flushes
	assign cell_c   = (cmd == cags_pkg::CMD_CELL) && (ir_q <= RB'(hlast_q)) && cell_value;

	// wrap, no_left, no_right, no_top, no_bottom
	assign ctl = {(ic_q == '0), (oc_q == '0), (oc_q >= wlast_q), (or_q == '0),
		(or_q >= hlast_q)};
	assign gen_end_c = ctl.no_right & ctl.no_bottom;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q <= '0;
			ir_q <= '0;
			oc_q <= '0;
			or_q <= '0;
		end else if (cfg_wr || (item_acc && emit && gen_end_c)) begin
			ic_q <= '0;
			ir_q <= '0;
			oc_q <= '0;
			or_q <= '0;
		end else if (item_acc) begin
			if (emit) begin
				if (oc_q >= wlast_q) begin
					oc_q <= '0;
					or_q <= or_q + GHB'(1);
				end else begin
					oc_q <= oc_q + CW'(1);
				end
			end
			if (ic_q >= wlast_q) begin
				ic_q <= '0;
				ir_q <= ir_q + RB'(1);
			end else begin
				ic_q <= ic_q + CW'(1);
			end
		end
	end

	cags_line_chain #(
		.DEPTH    (MAX_WIDTH),
		.IDX_BITS (CW)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (item_acc),
		.entry  (CW'(MAX_WIDTH - 1) - wlast_q),
		.din    ({hist[0], cell_c}),
		.dout   (hist)
	);

	cags_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (item_acc),
		.hist       (hist),
		.cell_in    (cell_c),
		.ctl        (ctl),
		.next_value (next_value_c)
	);

	// output register with skid stage
	logic res_valid_q, res_value_q, res_end_q;
	logic skid_valid_q, skid_value_q, skid_end_q;
	logic push, res_free;

	assign push     = item_acc & emit;
	assign res_free = ~res_valid_q | ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (res_free) begin
			if (skid_valid_q) begin
				res_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				res_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free) begin
			if (skid_valid_q) begin
				res_value_q <= skid_value_q;
				res_end_q   <= skid_end_q;
			end else if (push) begin
				res_value_q <= next_value_c;
				res_end_q   <= gen_end_c;
			end
		end
		if (push && (skid_valid_q || !res_free)) begin
			skid_value_q <= next_value_c;
			skid_end_q   <= gen_end_c;
		end
	end

	assign result_valid   = res_valid_q;
	assign next_value     = res_value_q;
	assign generation_end = res_end_q;
	assign item_stall     = skid_valid_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid stage full while output register empty");

	a_gen_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && emit && gen_end_c) |=>
		(ic_q == '0 && ir_q == '0 && oc_q == '0 && or_q == '0))
		else $error("positions not cleared after end of generation");

	a_cols_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ic_q <= wlast_q) && (oc_q <= wlast_q))
		else $error("column position beyond row width");

	a_rows_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(or_q <= hlast_q) && (ir_q <= RB'(hlast_q) + RB'(2)))
		else $error("row position beyond grid");

endmodule

`default_nettype wire

>>> dv/cellular_automaton_generation_step_top_tb.sv
// Self-checking bench for cellular_automaton_generation_step_top: a scoreboard tracks the
// grid and predicts every next-generation cell from the accepted transactions.
// Depends on cags_pkg and the block RTL; nothing else.
`default_nettype none

module cellular_automaton_generation_step_top_tb;

	localparam int LINE_MAX      = cags_pkg::DEFAULT_MAX_WIDTH;
	localparam logic CMD_FLUSH   = ~cags_pkg::CMD_CELL;
	localparam int IDLE_LIMIT    = 2000;
	localparam int RANDOM_ITEMS  = 420;
	localparam int SETTLE_CYCLES = 6;
	localparam int PRESSURE_AT   = 40;
	localparam int PRESSURE_HOLD = 300;
	localparam int GWB           = cags_pkg::GRID_WIDTH_BITS;
	localparam int GHB           = cags_pkg::GRID_HEIGHT_BITS;
	localparam int DB            = cags_pkg::APB_DATA_BITS;

	typedef struct packed {
		logic next_value;
		logic generation_end;
	} cell_result_t;

	class generation_scoreboard;
		logic [GWB-1:0] width_reg;
		logic [GHB-1:0] height_reg;
		logic [1:0] line_mem [LINE_MAX];
		logic [8:0] win;
		int unsigned in_col, in_row, out_col, out_row;
		cell_result_t pending_cells [$];
		int errors;

		function new();
			width_reg  = GWB'(cags_pkg::RESET_GRID_WIDTH);
			height_reg = GHB'(cags_pkg::RESET_GRID_HEIGHT);
			for (int i = 0; i < LINE_MAX; i++)
				line_mem[i] = 2'b00;
			win = '0;
			errors = 0;
			clear_positions();
		endfunction

		function void clear_positions();
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
		endfunction

		function int unsigned eff_width();
			if (width_reg == 0)
				return 1;
			if (width_reg > LINE_MAX)
				return LINE_MAX;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function logic [DB-1:0] reg_value(logic idx);
			if (idx == cags_pkg::REG_GRID_WIDTH)
				return DB'(width_reg);
			return DB'(height_reg);
		endfunction

		// any write abandons the generation in progress
		function void set_register(logic idx, logic [DB-1:0] data);
			if (idx == cags_pkg::REG_GRID_WIDTH)
				width_reg = data[GWB-1:0];
			else
				height_reg = data[GHB-1:0];
			clear_positions();
		endfunction

		function void absorb_item(logic c, logic v);
			int unsigned w, h, ic, ir;
			int cnt;
			logic [1:0] st;
			logic [2:0] newcol, l3, c3, r3;
			logic [8:0] sh;
			logic vin, emit, last;
			cell_result_t due;

			w  = eff_width();
			h  = eff_height();
			ic = in_col;
			ir = in_row;
			if (ic >= w)
				ic = w - 1;
			vin    = (c == cags_pkg::CMD_CELL && ir < h) ? v : 1'b0;
			st     = line_mem[ic];
			newcol = {st[1], st[0], vin};
			sh     = {win[5:0], newcol};
			emit   = (ir >= 2) || (ir == 1 && ic >= 1);
			last   = 1'b0;
			if (emit) begin
				// at column 0 the window has not yet taken the new column
				if (ic == 0) begin
					l3 = win[5:3];
					c3 = win[2:0];
					r3 = 3'b000;
				end else begin
					l3 = sh[8:6];
					c3 = sh[5:3];
					r3 = sh[2:0];
				end
				if (out_col == 0)
					l3 = 3'b000;
				if (out_col >= w - 1)
					r3 = 3'b000;
				if (out_row == 0) begin
					l3 &= 3'b011;
					c3 &= 3'b011;
					r3 &= 3'b011;
				end
				if (out_row >= h - 1) begin
					l3 &= 3'b110;
					c3 &= 3'b110;
					r3 &= 3'b110;
				end
				cnt = $countones(l3) + $countones(r3) + int'(c3[2]) + int'(c3[0]);
				last = (out_row >= h - 1) && (out_col >= w - 1);
				due.next_value     = c3[1] | (cnt == 1);
				due.generation_end = last;
				pending_cells.push_back(due);
				if (out_col + 1 >= w) begin
					out_col = 0;
					out_row++;
				end else begin
					out_col++;
				end
			end
			line_mem[ic] = {st[0], vin};
			win = sh;
			if (last) begin
				clear_positions();
			end else if (ic + 1 >= w) begin
				in_col = 0;
				in_row = ir + 1;
			end else begin
				in_col = ic + 1;
			end
		endfunction

		function void match_result(logic nv, logic ge);
			cell_result_t due;
			if (pending_cells.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: next_value %b generation_end %b",
					$time, nv, ge);
				return;
			end
			due = pending_cells.pop_front();
			if (nv !== due.next_value) begin
				errors++;
				$display("%0t: next_value expected %b actual %b", $time, due.next_value, nv);
			end
			if (ge !== due.generation_end) begin
				errors++;
				$display("%0t: generation_end expected %b actual %b",
					$time, due.generation_end, ge);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [cags_pkg::APB_ADDR_BITS-1:0] paddr = '0;
	logic [DB-1:0] pwdata = '0;
	logic [DB-1:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_stall;
	logic cmd = CMD_FLUSH;
	logic cell_value = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic next_value;
	logic generation_end;

	bit tx_quiet = 1'b0;
	int idle_cycles = 0;

	generation_scoreboard sb = new();

	cellular_automaton_generation_step_top #(.MAX_WIDTH(LINE_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.cmd(cmd),
		.cell_value(cell_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.next_value(next_value),
		.generation_end(generation_end)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || psel || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("cellular_automaton_generation_step_top_tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input logic c, input logic v);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd        <= c;
		cell_value <= v;
		do @(posedge clk); while (item_stall);
		sb.absorb_item(c, v);
	endtask

	task automatic apb_access(input logic idx, input logic wr,
		input logic [DB-1:0] data, output logic [DB-1:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_registers();
		logic [DB-1:0] rd;
		logic idx;
		for (int i = 0; i < 2; i++) begin
			idx = (i == 1) ? cags_pkg::REG_GRID_HEIGHT : cags_pkg::REG_GRID_WIDTH;
			apb_access(idx, 1'b0, '0, rd);
			if (rd !== sb.reg_value(idx)) begin
				sb.errors++;
				$display("%0t: register %0d read expected %h actual %h",
					$time, i, sb.reg_value(idx), rd);
			end
		end
	endtask

	// drain every result still in flight, then let the input idle
	task automatic settle();
		item_valid <= 1'b0;
		while (sb.pending_cells.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_grid(input int unsigned w, input int unsigned h);
		logic [DB-1:0] wdata, rd;
		settle();
		wdata = $urandom;
		wdata[GWB-1:0] = w[GWB-1:0];
		apb_access(cags_pkg::REG_GRID_WIDTH, 1'b1, wdata, rd);
		sb.set_register(cags_pkg::REG_GRID_WIDTH, wdata);
		wdata = $urandom;
		wdata[GHB-1:0] = h[GHB-1:0];
		apb_access(cags_pkg::REG_GRID_HEIGHT, 1'b1, wdata, rd);
		sb.set_register(cags_pkg::REG_GRID_HEIGHT, wdata);
		check_registers();
	endtask

	// grid cells first (noise: flush in place of a cell), then trailing items
	// (noise: a cell after the grid)
	task automatic send_generation(input int unsigned cells, input int unsigned tail,
		input int unsigned density, input int unsigned noise, inout int unsigned sent);
		logic c, v;
		for (int unsigned i = 0; i < cells + tail; i++) begin
			v = ($urandom_range(0, 99) < density);
			if (i < cells)
				c = ($urandom_range(0, 99) < noise) ? CMD_FLUSH : cags_pkg::CMD_CELL;
			else
				c = ($urandom_range(0, 99) < noise) ? cags_pkg::CMD_CELL : CMD_FLUSH;
			send_item(c, v);
		end
		sent += cells + tail;
	endtask

	initial begin : result_sink
		int hold;
		int unsigned taken;
		bit rx_quiet;
		taken = 0;
		rx_quiet = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 32 == 0)
				rx_quiet = ($urandom_range(0, 4) == 0);
			hold = rx_quiet ? 0 : $urandom_range(0, 3);
			// one long back-pressure stretch so the block fills and stalls its input
			if (taken == PRESSURE_AT)
				hold = PRESSURE_HOLD;
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			sb.match_result(next_value, generation_end);
			taken++;
		end
	end

	initial begin
		localparam logic [12:0] DIR_CMD = 13'b1101000100000;
		localparam logic [12:0] DIR_VAL = 13'b0010100100001;
		int unsigned sent, w, h, wd, hd, cells, tail, density;
		bit broken;

		sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_registers();

		// reset geometry 1024 x 1024: nothing comes out within the first row
		for (int i = 0; i < 24; i++)
			send_item(cags_pkg::CMD_CELL, $urandom_range(0, 1) == 1);

		// 3x3: flush inside the grid, then a cell after the grid among the trailing items
		write_grid(3, 3);
		for (int i = 0; i < 13; i++)
			send_item(DIR_CMD[i], DIR_VAL[i]);

		// zero width and height act as a single cell
		write_grid(0, 0);
		for (int i = 0; i < 6; i++)
			send_item((i % 3 == 0) ? cags_pkg::CMD_CELL : CMD_FLUSH, i == 0);

		// widest grid, clamped from the top of the register range; abandoned in row 0
		write_grid(2047, 1);
		send_generation(30, 0, 50, 5, sent);

		// tallest grid, abandoned part way by the next write
		write_grid(1, 65535);
		send_generation(60, 0, 30, 5, sent);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: w = 0;
				1: w = $urandom_range(9, 24);
				default: w = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 9))
				0: h = 0;
				1: h = $urandom_range(7, 12);
				default: h = $urandom_range(1, 6);
			endcase
			write_grid(w, h);
			wd = (w == 0) ? 1 : w;
			hd = (h == 0) ? 1 : h;
			for (int g = $urandom_range(1, 3); g > 0; g--) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				density  = $urandom_range(0, 100);
				broken   = ($urandom_range(0, 7) == 0);
				cells    = broken ? $urandom_range(0, wd * hd) : wd * hd;
				tail     = broken ? $urandom_range(0, wd) : wd + 1;
				send_generation(cells, tail, density, $urandom_range(0, 10), sent);
				if (broken || sent >= RANDOM_ITEMS)
					break;
			end
		end

		settle();
		if (sb.errors == 0)
			$display("cellular_automaton_generation_step_top_tb: clean");
		else
			$display("cellular_automaton_generation_step_top_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
design/cags_pkg.sv
design/cags_cell.sv
design/cags_line_chain.sv
design/cags_window.sv
design/cellular_automaton_generation_step_top.sv
dv/cellular_automaton_generation_step_top_tb.sv
